[hw/rtl/assert_macros.svh]
// Assertion macros for RTL that checks itself; maze_backtracker_step includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, ck, rstn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (prop)) \
		else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, ck, rstn, prop)
`define ASSERT_IMPLIES(lbl, ck, rstn, ante, cons)
`define ASSERT_NEXT(lbl, ck, rstn, ante, cons)
`endif
`endif

[hw/rtl/mbt_pkg.sv]
// Shared types, codes and helpers of the maze backtracker.
package mbt_pkg;

	localparam int MAX_ROWS_DEF = 32;
	localparam int MAX_COLS_DEF = 32;

	localparam int GRID_W      = 6;
	localparam int CFG_IDX_W   = 1;
	localparam int RND_W       = 16;
	localparam int ACTION_W    = 2;
	localparam int CELL_OUT_W  = 5;
	localparam int DIR_W       = 2;

	localparam logic [GRID_W-1:0] GRID_RESET = 6'd16;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 1'd1;

	localparam logic [ACTION_W-1:0] ACT_CARVED    = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_BACKTRACK = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_FINISHED  = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_RESTARTED = 2'd3;

	localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
	localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
	localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
	localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd3;

	// Which visited row the datapath addresses this cycle.
	typedef enum logic [1:0] {
		RD_UP  = 2'd0,
		RD_MID = 2'd1,
		RD_DN  = 2'd2
	} rd_sel_t;

	typedef struct packed {
		logic    accept;
		logic    clr_start;
		logic    clr_step;
		rd_sel_t rd_sel;
		logic    cap_up;
		logic    cap_mid;
		logic    carve;
		logic    pop_start;
		logic    pop_finish;
		logic    finish_load;
		logic    restart_load;
	} cmd_t;

	typedef struct packed {
		logic req_restart;
		logic has_free;
		logic stk_empty;
		logic clr_last;
	} sts_t;

	// Residue mod 3 of a 16-bit value: 4 = 1 (mod 3), so fold base-4 digits.
	function automatic logic [1:0] mod3_u16(input logic [RND_W-1:0] v);
		logic [4:0] s;
		logic [3:0] t;
		logic [2:0] u;
		s = '0;
		for (int i = 0; i < RND_W / 2; i++) begin
			s = s + 5'(v[2*i +: 2]);
		end
		t = 4'(s[4:2]) + 4'(s[1:0]);
		u = 3'(t[3:2]) + 3'(t[1:0]);
		if (u >= 3'd3) begin
			u = u - 3'd3;
		end
		return u[1:0];
	endfunction

endpackage

[hw/rtl/mbt_req_if.sv]
// Request channel: one step or restart transaction per handshake.
interface mbt_req_if;
	import mbt_pkg::*;

	logic             valid;
	logic             ready;
	logic             func;
	logic [RND_W-1:0] random_value;

	modport source (output valid, func, random_value, input ready);
	modport sink   (input valid, func, random_value, output ready);
endinterface

[hw/rtl/mbt_rsp_if.sv]
// Response channel: one result transaction per accepted request.
interface mbt_rsp_if;
	import mbt_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [ACTION_W-1:0]   action;
	logic [CELL_OUT_W-1:0] cell_col;
	logic [CELL_OUT_W-1:0] cell_row;
	logic [DIR_W-1:0]      carve_dir;

	modport source (output valid, action, cell_col, cell_row, carve_dir, input ready);
	modport sink   (input valid, action, cell_col, cell_row, carve_dir, output ready);
endinterface

[hw/rtl/maze_backtracker_step.sv]
// Top level of the randomized depth-first maze backtracker.
//
//  port      | role    | carries
//  ----------+---------+-------------------------------------------------
//  req       | sink    | func (step / restart), random_value
//  rsp       | source  | action, cell_col, cell_row, carve_dir
//  cfg_*     | write   | grid_rows (index 0), grid_cols (index 1)
//
// After accept a step passes through RD_MID, RD_DN and DECIDE (and POP when it
// backtracks); the result is registered when DECIDE or POP loads it, and the next
// request is taken back in IDLE; the rows above, at and below the current cell pass
// one at a time through the single read port of the visited-row memory; a backtrack
// adds a stack read. Reset and restart run a clearing pass, one visited row a cycle,
// with req.ready low; a restart result follows the pass.
// A result waiting on rsp does not block the next request; it only holds the
// next result load.
`include "assert_macros.svh"

module maze_backtracker_step #(
	parameter int MAX_ROWS = mbt_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = mbt_pkg::MAX_COLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	mbt_req_if.sink                       req,
	mbt_rsp_if.source                     rsp,
	input  logic                          cfg_wen,
	input  logic [mbt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mbt_pkg::GRID_W-1:0]    cfg_data
);
	import mbt_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic in_ready;
	logic out_valid;
	logic res_load;
	logic [4:0] upd_vec;

	mbt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mbt_dpath #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.in_func         (req.func),
		.in_random_value (req.random_value),
		.cfg_wen         (cfg_wen),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.action          (rsp.action),
		.cell_col        (rsp.cell_col),
		.cell_row        (rsp.cell_row),
		.carve_dir       (rsp.carve_dir)
	);

	assign req.ready = in_ready;
	assign rsp.valid = out_valid;

	assign res_load = cmd.carve | cmd.pop_finish | cmd.finish_load | cmd.restart_load;
	assign upd_vec  = {cmd.carve, cmd.pop_start, cmd.pop_finish, cmd.finish_load,
		cmd.restart_load};

	`ASSERT_IMPLIES(a_load_slot_free, clk, arst_n, res_load, !rsp.valid || rsp.ready)
	`ASSERT_IMPLIES(a_pop_nonempty, clk, arst_n, cmd.pop_start, !sts.stk_empty)
	`ASSERT_NEXT(a_busy_after_step, clk, arst_n, cmd.accept && !sts.req_restart, !req.ready)
	`ASSERT_ALWAYS(a_single_update, clk, arst_n, $onehot0(upd_vec))

endmodule

[hw/rtl/mbt_ctrl.sv]
// Sequencer of the maze backtracker: handshakes, clearing sweep, step phases.
module mbt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  mbt_pkg::sts_t sts,
	output mbt_pkg::cmd_t cmd
);
	import mbt_pkg::*;

	typedef enum logic [5:0] {
		S_CLEAR  = 6'b000001,
		S_IDLE   = 6'b000010,
		S_RD_MID = 6'b000100,
		S_RD_DN  = 6'b001000,
		S_DECIDE = 6'b010000,
		S_POP    = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   restart_q;
	logic   out_valid_q;
	logic   out_free;
	logic   load;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign load      = cmd.carve | cmd.pop_finish | cmd.finish_load | cmd.restart_load;

	always_comb begin
		cmd     = '0;
		cmd.rd_sel = RD_UP;
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					if (!restart_q) begin
						state_d = S_IDLE;
					end else if (out_free) begin
						cmd.restart_load = 1'b1;
						state_d = S_IDLE;
					end
				end
			end
			S_IDLE: begin
				// read the row above while waiting, so a step starts with it
				cmd.rd_sel = RD_UP;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (sts.req_restart) begin
						cmd.clr_start = 1'b1;
						state_d = S_CLEAR;
					end else begin
						state_d = S_RD_MID;
					end
				end
			end
			S_RD_MID: begin
				cmd.rd_sel = RD_MID;
				cmd.cap_up = 1'b1;
				state_d = S_RD_DN;
			end
			S_RD_DN: begin
				cmd.rd_sel  = RD_DN;
				cmd.cap_mid = 1'b1;
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				// hold the row below on the read port while the result slot is busy
				cmd.rd_sel = RD_DN;
				if (sts.has_free) begin
					if (out_free) begin
						cmd.carve = 1'b1;
						state_d = S_IDLE;
					end
				end else if (!sts.stk_empty) begin
					cmd.pop_start = 1'b1;
					state_d = S_POP;
				end else if (out_free) begin
					cmd.finish_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_POP: begin
				if (out_free) begin
					cmd.pop_finish = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			restart_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= load | (out_valid_q & !out_ready);
			if (cmd.accept) begin
				restart_q <= sts.req_restart;
			end
		end
	end

endmodule

[hw/rtl/mbt_dpath.sv]
// Datapath of the maze backtracker: visited rows, cell stack, neighbour pick.
module mbt_dpath #(
	parameter int MAX_ROWS = mbt_pkg::MAX_ROWS_DEF,
	parameter int MAX_COLS = mbt_pkg::MAX_COLS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mbt_pkg::cmd_t                     cmd,
	output mbt_pkg::sts_t                     sts,
	input  logic                              in_func,
	input  logic [mbt_pkg::RND_W-1:0]         in_random_value,
	input  logic                              cfg_wen,
	input  logic [mbt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mbt_pkg::GRID_W-1:0]        cfg_data,
	output logic [mbt_pkg::ACTION_W-1:0]      action,
	output logic [mbt_pkg::CELL_OUT_W-1:0]    cell_col,
	output logic [mbt_pkg::CELL_OUT_W-1:0]    cell_row,
	output logic [mbt_pkg::DIR_W-1:0]         carve_dir
);
	import mbt_pkg::*;

	localparam int RW      = $clog2(MAX_ROWS);
	localparam int CW      = $clog2(MAX_COLS);
	localparam int CELLS   = MAX_ROWS * MAX_COLS;
	localparam int SAW     = $clog2(CELLS);
	localparam int SDW     = $clog2(CELLS + 1);
	localparam int MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
	localparam int DIM_W   = $clog2(MAX_DIM + 2);
	localparam int CMP_W   = (DIM_W > GRID_W) ? DIM_W : GRID_W;

	// visited bits, one row of the grid per word
	logic [MAX_COLS-1:0] vis_mem [MAX_ROWS];
	logic [RW+CW-1:0]    stk_mem [CELLS];

	logic [GRID_W-1:0]   grid_rows_q, grid_cols_q;
	logic [RW-1:0]       row_q;
	logic [CW-1:0]       col_q;
	logic [SDW-1:0]      depth_q;
	logic [RW-1:0]       clr_row_q;
	logic [1:0]          rnd_low_q;
	logic [1:0]          rnd_m3_q;
	logic [MAX_COLS-1:0] up_q, mid_q, vis_rd_q;
	logic [RW+CW-1:0]    stk_rd_q;
	logic [ACTION_W-1:0]   action_q;
	logic [CELL_OUT_W-1:0] res_col_q, res_row_q;
	logic [DIR_W-1:0]      dir_q;

	logic [CMP_W-1:0]    rows_x, cols_x, r_x, c_x;
	logic [CW-1:0]       col_r, col_l;
	logic [3:0]          free;
	logic [2:0]          n_free;
	logic [1:0]          kk;
	logic [2:0]          cnt;
	logic [DIR_W-1:0]    sel;
	logic [RW-1:0]       nxt_row;
	logic [CW-1:0]       nxt_col;
	logic [MAX_COLS-1:0] wrow;
	logic                clr_last;
	logic                vis_we;
	logic [RW-1:0]       vis_waddr, vis_raddr;
	logic [MAX_COLS-1:0] vis_wdata;
	logic                push_en;
	logic [SAW-1:0]      stk_raddr;

	// out-of-range register values: zero counts as one, above maximum as maximum
	always_comb begin
		rows_x = CMP_W'(grid_rows_q);
		if (grid_rows_q == '0) begin
			rows_x = CMP_W'(1);
		end else if (CMP_W'(grid_rows_q) > CMP_W'(MAX_ROWS)) begin
			rows_x = CMP_W'(MAX_ROWS);
		end
		cols_x = CMP_W'(grid_cols_q);
		if (grid_cols_q == '0) begin
			cols_x = CMP_W'(1);
		end else if (CMP_W'(grid_cols_q) > CMP_W'(MAX_COLS)) begin
			cols_x = CMP_W'(MAX_COLS);
		end
	end

	assign r_x   = CMP_W'(row_q);
	assign c_x   = CMP_W'(col_q);
	assign col_r = (col_q == CW'(MAX_COLS - 1)) ? col_q : col_q + CW'(1);
	assign col_l = (col_q == '0) ? col_q : col_q - CW'(1);

	// the current cell may sit outside a shrunk grid; only in-grid neighbours count
	assign free[0] = (row_q != '0) && (r_x - CMP_W'(1) < rows_x) && (c_x < cols_x)
		&& !up_q[col_q];
	assign free[1] = (c_x + CMP_W'(1) < cols_x) && (r_x < rows_x) && !mid_q[col_r];
	assign free[2] = (r_x + CMP_W'(1) < rows_x) && (c_x < cols_x) && !vis_rd_q[col_q];
	assign free[3] = (col_q != '0) && (c_x - CMP_W'(1) < cols_x) && (r_x < rows_x)
		&& !mid_q[col_l];

	assign n_free = 3'($countones(free));

	always_comb begin
		kk = 2'd0;
		unique case (n_free)
			3'd2:    kk = {1'b0, rnd_low_q[0]};
			3'd3:    kk = rnd_m3_q;
			3'd4:    kk = rnd_low_q;
			default: kk = 2'd0;
		endcase
	end

	// take the kk-th free neighbour in the order up, right, down, left
	always_comb begin
		sel = DIR_UP;
		cnt = '0;
		for (int i = 0; i < 4; i++) begin
			if (free[i]) begin
				if (cnt == {1'b0, kk}) begin
					sel = DIR_W'(i);
				end
				cnt = cnt + 3'd1;
			end
		end
	end

	always_comb begin
		nxt_row = row_q;
		nxt_col = col_q;
		wrow    = mid_q;
		unique case (sel)
			DIR_UP: begin
				nxt_row = row_q - RW'(1);
				wrow    = up_q | (MAX_COLS'(1) << col_q);
			end
			DIR_RIGHT: begin
				nxt_col = col_r;
				wrow    = mid_q | (MAX_COLS'(1) << col_r);
			end
			DIR_DOWN: begin
				nxt_row = row_q + RW'(1);
				wrow    = vis_rd_q | (MAX_COLS'(1) << col_q);
			end
			DIR_LEFT: begin
				nxt_col = col_l;
				wrow    = mid_q | (MAX_COLS'(1) << col_l);
			end
		endcase
	end

	assign clr_last = (clr_row_q == RW'(MAX_ROWS - 1));

	always_comb begin
		vis_we    = 1'b0;
		vis_waddr = clr_row_q;
		vis_wdata = '0;
		if (cmd.clr_step) begin
			vis_we    = 1'b1;
			// row zero comes back with the top-left cell marked
			vis_wdata = (clr_row_q == '0) ? MAX_COLS'(1) : '0;
		end else if (cmd.carve) begin
			vis_we    = 1'b1;
			vis_waddr = nxt_row;
			vis_wdata = wrow;
		end
	end

	always_comb begin
		vis_raddr = row_q;
		unique case (cmd.rd_sel)
			RD_UP:   vis_raddr = (row_q == '0) ? row_q : row_q - RW'(1);
			RD_MID:  vis_raddr = row_q;
			RD_DN:   vis_raddr = (row_q == RW'(MAX_ROWS - 1)) ? row_q : row_q + RW'(1);
			default: vis_raddr = row_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (vis_we) begin
			vis_mem[vis_waddr] <= vis_wdata;
		end
		vis_rd_q <= vis_mem[vis_raddr];
	end

	// a push onto a full stack is dropped
	assign push_en   = cmd.carve && (depth_q != SDW'(CELLS));
	assign stk_raddr = SAW'(depth_q - SDW'(1));

	always_ff @(posedge clk) begin
		if (push_en) begin
			stk_mem[SAW'(depth_q)] <= {row_q, col_q};
		end
		if (cmd.pop_start) begin
			stk_rd_q <= stk_mem[stk_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= GRID_RESET;
			grid_cols_q <= GRID_RESET;
			row_q       <= '0;
			col_q       <= '0;
			depth_q     <= '0;
			clr_row_q   <= '0;
		end else begin
			if (cfg_wen) begin
				unique case (cfg_index)
					CFG_GRID_ROWS: grid_rows_q <= cfg_data;
					CFG_GRID_COLS: grid_cols_q <= cfg_data;
				endcase
			end
			if (cmd.clr_start) begin
				row_q     <= '0;
				col_q     <= '0;
				depth_q   <= '0;
				clr_row_q <= '0;
			end
			if (cmd.clr_step && !clr_last) begin
				clr_row_q <= clr_row_q + RW'(1);
			end
			if (cmd.carve) begin
				row_q <= nxt_row;
				col_q <= nxt_col;
				if (push_en) begin
					depth_q <= depth_q + SDW'(1);
				end
			end
			if (cmd.pop_start) begin
				depth_q <= depth_q - SDW'(1);
			end
			if (cmd.pop_finish) begin
				{row_q, col_q} <= stk_rd_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			rnd_low_q <= in_random_value[1:0];
			rnd_m3_q  <= mod3_u16(in_random_value);
		end
		if (cmd.cap_up) begin
			up_q <= vis_rd_q;
		end
		if (cmd.cap_mid) begin
			mid_q <= vis_rd_q;
		end
		if (cmd.carve) begin
			action_q  <= ACT_CARVED;
			res_col_q <= CELL_OUT_W'(nxt_col);
			res_row_q <= CELL_OUT_W'(nxt_row);
			dir_q     <= sel;
		end else if (cmd.pop_finish) begin
			action_q  <= ACT_BACKTRACK;
			res_col_q <= CELL_OUT_W'(stk_rd_q[CW-1:0]);
			res_row_q <= CELL_OUT_W'(stk_rd_q[RW+CW-1:CW]);
			dir_q     <= DIR_UP;
		end else if (cmd.finish_load) begin
			action_q  <= ACT_FINISHED;
			res_col_q <= CELL_OUT_W'(col_q);
			res_row_q <= CELL_OUT_W'(row_q);
			dir_q     <= DIR_UP;
		end else if (cmd.restart_load) begin
			action_q  <= ACT_RESTARTED;
			res_col_q <= '0;
			res_row_q <= '0;
			dir_q     <= DIR_UP;
		end
	end

	assign sts.req_restart = in_func;
	assign sts.has_free    = (n_free != 3'd0);
	assign sts.stk_empty   = (depth_q == '0);
	assign sts.clr_last    = clr_last;

	assign action    = action_q;
	assign cell_col  = res_col_q;
	assign cell_row  = res_row_q;
	assign carve_dir = dir_q;

endmodule
